### design/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH  = 8;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned OCC_W  = 4;

  // Operation codes carried in func
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_DEQUEUED  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell
  typedef struct packed {
    logic   enq;   // insert, queue known not full
    logic   deq;   // pop head, queue known not empty
    entry_t ent;   // entry being inserted
  } cell_ctrl_t;

  // Per-cell view of its position and neighbours
  typedef struct packed {
    logic   occ;      // cell holds a live entry
    logic   at_tail;  // first free cell
    logic   left_gt;  // left neighbour is occupied and outranked by the new entry
    entry_t left;
    entry_t right;
  } cell_nbr_t;

endpackage

### design/spq_in_if.sv
`timescale 1ns / 1ps

interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [VAL_W-1:0]  value_in;
  logic signed [PRIO_W-1:0] prio_in;

  modport source (output valid, output func, output value_in, output prio_in, input ready);
  modport sink   (input valid, input func, input value_in, input prio_in, output ready);
endinterface

### design/spq_out_if.sv
`timescale 1ns / 1ps

interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [VAL_W-1:0]  value_out;
  logic signed [PRIO_W-1:0] prio_out;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output value_out, output prio_out,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input value_out, input prio_out,
                  input occupancy, output ready);
endinterface

### design/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  cell_nbr_t  nbr_i,
  output logic       gt_o,
  output entry_t     ent_o
);

  entry_t ent_q, ent_d;

  // Stored entry sorts after the incoming one
  assign gt_o = nbr_i.occ && ($signed(ent_q.prio) > $signed(ctrl_i.ent.prio));

  // Insert: cells from the insertion point up shift right by one,
  // the cell at the insertion point takes the new entry.
  // Pop: every cell takes its right neighbour.
  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.enq && (gt_o || nbr_i.at_tail)) begin
      ent_d = nbr_i.left_gt ? nbr_i.left : ctrl_i.ent;
    end else if (ctrl_i.deq) begin
      ent_d = nbr_i.right;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

### design/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Interface   Payload
// req_i    in   spq_in_if   func, value_in, prio_in
// rsp_o    out  spq_out_if  status, value_out, prio_out, occupancy
//
// One request per cycle while the response is not stalled; every cell compares against the new priority at once.
// The response appears in the output register the cycle after acceptance.
// req_i.ready is high while the output register is empty or being drained.
// Reset clears the entry count and the output valid; cell contents are not reset.
// A stalled response holds the output register and blocks further requests.

module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    req_i,
  spq_out_if.source rsp_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             fire, full, empty, is_enq;
  cell_ctrl_t       ctrl;
  cell_nbr_t        nbr  [DEPTH];
  entry_t           ents [DEPTH];
  logic             gts  [DEPTH];

  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic signed [VAL_W-1:0]  value_q, value_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;

  // Handshake and queue level
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign full        = (count_q == CNT_W'(DEPTH));
  assign empty       = (count_q == '0);
  assign is_enq      = (req_i.func == FUNC_ENQ);

  assign ctrl.enq       = fire && is_enq && !full;
  assign ctrl.deq       = fire && !is_enq && !empty;
  assign ctrl.ent.value = req_i.value_in;
  assign ctrl.ent.prio  = req_i.prio_in;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign nbr[i].occ     = (CNT_W'(i) < count_q);
    assign nbr[i].at_tail = (CNT_W'(i) == count_q);
    if (i == 0) begin : g_head
      assign nbr[i].left_gt = 1'b0;
      assign nbr[i].left    = ctrl.ent;
    end else begin : g_body
      assign nbr[i].left_gt = gts[i-1];
      assign nbr[i].left    = ents[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nbr[i].right = ents[i];
    end else begin : g_mid
      assign nbr[i].right = ents[i+1];
    end

    spq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .nbr_i  (nbr[i]),
      .gt_o   (gts[i]),
      .ent_o  (ents[i])
    );
  end

  // Count update
  always_comb begin
    count_d = count_q;
    if (ctrl.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Response payload
  always_comb begin
    value_d = '0;
    prio_d  = '0;
    if (is_enq) begin
      status_d = full ? ST_OVERFLOW : ST_ENQUEUED;
    end else if (empty) begin
      status_d = ST_UNDERFLOW;
    end else begin
      status_d = ST_DEQUEUED;
      value_d  = ents[0].value;
      prio_d   = ents[0].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      value_q  <= value_d;
      prio_q   <= prio_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.value_out = value_q;
  assign rsp_o.prio_out  = prio_q;
  assign rsp_o.occupancy = OCC_W'(count_q);

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.enq |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CNT_W'(2) |-> $signed(ents[0].prio) <= $signed(ents[1].prio))
    else $error("head entries out of order");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_UNDERFLOW) |-> rsp_o.occupancy == '0)
    else $error("underflow reported with entries stored");

endmodule

### sim/spq_checker.sv
`timescale 1ns / 1ps

module spq_checker
  import spq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  spq_in_if    req,
  spq_out_if   rsp,
  output int   err_cnt_o,
  output int   pending_o,
  output int   rsp_cnt_o,
  output int   ovf_cnt_o,
  output int   udf_cnt_o,
  output int   full_cnt_o
);

  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]         occ;
  } spq_rsp_t;

  // Shadow copy of the queue, head at index 0
  entry_t      shadow_q [DEPTH];
  int unsigned shadow_fill;

  spq_rsp_t    rsp_expected_q [$];

  // Apply one request to the shadow queue and return the response it should give
  function automatic spq_rsp_t next_response(logic f, entry_t ent);
    spq_rsp_t    r;
    int unsigned pos;
    r = '{status: ST_ENQUEUED, value: '0, prio: '0, occ: '0};
    if (f == FUNC_ENQ) begin
      if (shadow_fill >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // Shift every strictly larger priority one place towards the tail
        pos = shadow_fill;
        while (pos > 0 && $signed(shadow_q[pos-1].prio) > $signed(ent.prio)) begin
          shadow_q[pos] = shadow_q[pos-1];
          pos--;
        end
        shadow_q[pos] = ent;
        shadow_fill++;
        r.status = ST_ENQUEUED;
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.status = ST_DEQUEUED;
        r.value  = shadow_q[0].value;
        r.prio   = shadow_q[0].prio;
        for (int i = 1; i < shadow_fill; i++) begin
          shadow_q[i-1] = shadow_q[i];
        end
        shadow_fill--;
      end
    end
    r.occ = shadow_fill[OCC_W-1:0];
    return r;
  endfunction

  function automatic void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    err_cnt_o++;
    if (err_cnt_o <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
    end
  endfunction

  // Responses are retired before requests are logged: the response is registered, so
  // a response can never belong to the request taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    spq_rsp_t exp_r;
    entry_t   ent;
    if (!rst_ni) begin
      shadow_fill = 0;
      rsp_expected_q.delete();
      err_cnt_o  = 0;
      pending_o  = 0;
      rsp_cnt_o  = 0;
      ovf_cnt_o  = 0;
      udf_cnt_o  = 0;
      full_cnt_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rsp_cnt_o++;
        if (rsp_expected_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: response with none outstanding, status %0d occupancy %0d",
                   $time, rsp.status, rsp.occupancy);
        end else begin
          exp_r = rsp_expected_q.pop_front();
          if (rsp.status !== exp_r.status) report("status", exp_r.status, rsp.status);
          if (rsp.value_out !== exp_r.value) report("value_out", exp_r.value, rsp.value_out);
          if (rsp.prio_out !== exp_r.prio) report("prio_out", exp_r.prio, rsp.prio_out);
          if (rsp.occupancy !== exp_r.occ) report("occupancy", exp_r.occ, rsp.occupancy);
        end
      end
      if (req.valid && req.ready) begin
        ent.value = req.value_in;
        ent.prio  = req.prio_in;
        exp_r = next_response(req.func, ent);
        if (exp_r.status == ST_OVERFLOW) ovf_cnt_o++;
        if (exp_r.status == ST_UNDERFLOW) udf_cnt_o++;
        if (shadow_fill == DEPTH) full_cnt_o++;
        rsp_expected_q.push_back(exp_r);
      end
      pending_o = rsp_expected_q.size();
    end
  end

endmodule

### sim/sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
  import spq_pkg::*;

  localparam int N_RANDOM  = 1200;
  localparam int CALM_FROM = 1000;  // no idling past this request
  localparam int WD_LIMIT  = 1000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spq_in_if  req ();
  spq_out_if rsp ();

  int err_cnt, pending, rsp_cnt, ovf_cnt, udf_cnt, full_cnt;
  int wd_cnt;
  bit stall_en;
  bit gap_en;

  sorted_priority_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  spq_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending),
    .rsp_cnt_o  (rsp_cnt),
    .ovf_cnt_o  (ovf_cnt),
    .udf_cnt_o  (udf_cnt),
    .full_cnt_o (full_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WD_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  // Response side back-pressure in bursts
  initial begin
    rsp.ready <= 1'b1;
    @(posedge rst_ni);
    forever begin
      if (stall_en && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Issue one request and hold it until taken
  task automatic send_req(input logic f, input logic signed [VAL_W-1:0] v,
                          input logic signed [PRIO_W-1:0] p);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.func     <= f;
    req.value_in <= v;
    req.prio_in  <= p;
    do @(posedge clk_i); while (!req.ready);
  endtask

  // Priority draw: sometimes the extremes or a narrow band to force ties, mostly full range
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3, 4: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int enq_pct;
    logic f;
    req.valid    <= 1'b0;
    req.func     <= FUNC_ENQ;
    req.value_in <= '0;
    req.prio_in  <= '0;
    stall_en = 1'b1;
    gap_en   = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, extremes, ties in arrival order, full insert, drain
    send_req(FUNC_DEQ, 32'sh0, 16'sh0);
    send_req(FUNC_ENQ, 32'sh7fffffff, 16'sh7fff);
    send_req(FUNC_ENQ, 32'sh80000000, 16'sh8000);
    send_req(FUNC_ENQ, 32'shffffffff, 16'shffff);
    send_req(FUNC_ENQ, 32'sh0, 16'sh0);
    send_req(FUNC_ENQ, 32'sh1, 16'sh0);
    send_req(FUNC_ENQ, 32'sh2, 16'sh0);
    send_req(FUNC_ENQ, 32'sh55555555, 16'sh5555);
    send_req(FUNC_ENQ, 32'shaaaaaaaa, 16'shaaaa);
    send_req(FUNC_ENQ, 32'sh12345678, 16'sh0);
    repeat (8) send_req(FUNC_DEQ, 32'shffffffff, 16'shffff);
    send_req(FUNC_DEQ, 32'sh0, 16'sh0);
    send_req(FUNC_ENQ, 32'sh600d, 16'sh8000);
    send_req(FUNC_DEQ, 32'sh0, 16'sh0);

    // Random: enqueue bias is redrawn every 40 requests so the queue swings
    // between full and empty
    enq_pct = 50;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 20;
          1:       enq_pct = 50;
          default: enq_pct = 80;
        endcase
      end
      stall_en = (i < CALM_FROM) && ((i / 100) % 4 != 3);
      gap_en   = (i < CALM_FROM) && ((i / 100) % 4 != 2);
      f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      send_req(f, 32'($urandom), pick_prio());
    end
    req.valid <= 1'b0;

    // Drain; the watchdog bounds this wait
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d responses checked: %0d overflow, %0d underflow, queue full %0d times",
             rsp_cnt, ovf_cnt, udf_cnt, full_cnt);
    $display("%0d mismatches", err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
